// File: hw/rtl/bfe_pkg.sv
package bfe_pkg;
    localparam int MaxBits   = 65536;
    localparam int MaxHashes = 16;
    localparam int AddrW     = $clog2(MaxBits);
    localparam int NumW      = AddrW + 1;
    localparam int HashW     = $clog2(MaxHashes) + 1;
    localparam int KeyW      = 32;
    localparam int QDepth    = 2;
    localparam int QIdxW     = $clog2(QDepth);
    localparam logic [KeyW-1:0] GoldenMix = 32'h9e3779b9;

    localparam logic [1:0] RegNumBits   = 2'd0;
    localparam logic [1:0] RegHashCount = 2'd1;
    localparam logic [1:0] RegMinKey    = 2'd2;
    localparam logic [1:0] RegMaxKey    = 2'd3;

    localparam logic OpInsert = 1'b0;
    localparam logic OpQuery  = 1'b1;

    // classified job handed from front to back
    typedef struct packed {
        logic            op;
        logic            in_range;
        logic            probe;
        logic [KeyW-1:0] key;
    } t_job;
endpackage

// File: hw/rtl/bfe_ram.sv
module bfe_ram #(
    parameter int Width = 1,
    parameter int Depth = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bfe_front.sv
module bfe_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_op,
    input  logic signed [31:0]    i_key,
    input  logic signed [31:0]    i_min_key,
    input  logic signed [31:0]    i_max_key,
    input  logic                  i_probe_en,
    output logic                  o_job_valid,
    input  logic                  i_job_take,
    output bfe_pkg::t_job         o_job
);
    import bfe_pkg::*;

    t_job               r_q [QDepth];
    logic [QIdxW-1:0]   r_wp, r_rp;
    logic [QIdxW:0]     r_cnt;
    logic               push;
    logic               pop;
    t_job               new_job;

    // classify: range check and whether any probe runs
    always_comb begin
        new_job.op       = i_op;
        new_job.key      = i_key;
        new_job.in_range = (i_key >= i_min_key) && (i_key <= i_max_key);
        new_job.probe    = i_probe_en;
    end

    assign o_stall     = (r_cnt == (QIdxW+1)'(QDepth));
    assign push        = i_valid && !o_stall;
    assign pop         = i_job_take && (r_cnt != '0);
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= new_job;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QIdxW+1)'(push) - (QIdxW+1)'(pop);
        end
    end
endmodule

// File: hw/rtl/bfe_back.sv
module bfe_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_take,
    input  bfe_pkg::t_job               i_job,
    input  logic [bfe_pkg::NumW-1:0]    i_mod,
    input  logic [bfe_pkg::HashW-1:0]   i_hashes,
    output logic                        o_busy_clear,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_may_contain,
    output logic                        o_in_range
);
    import bfe_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_REDUCE, S_READ, S_CHECK, S_OUT
    } t_state;

    localparam int SumW = KeyW + 1;
    localparam int ShW  = NumW + KeyW - 1;

    t_state             r_state;
    logic [AddrW-1:0]   r_clr;
    t_job               r_job;
    logic [HashW-1:0]   r_idx;
    logic [SumW-1:0]    r_pos;    // running (h1 + i*h2) mod M
    logic [SumW-1:0]    r_step;   // h2 mod M
    logic [5:0]         r_cnt;    // reduction step counter
    logic [SumW-1:0]    r_red;
    logic               r_may;
    logic               r_valid;
    logic               r_may_o;
    logic               r_rng_o;
    logic [AddrW-1:0]   ram_waddr;
    logic               ram_we;
    logic               ram_wdata;
    logic               ram_rdata;
    logic [SumW-1:0]    mod_ext;
    logic [ShW-1:0]     mod_sh;
    logic [SumW-1:0]    sum;
    logic [SumW-1:0]    sum_red;
    logic               last_probe;

    assign mod_ext    = SumW'(i_mod);
    assign mod_sh     = ShW'(i_mod) << r_cnt[4:0];
    assign sum        = r_pos + r_step;
    assign sum_red    = (sum >= mod_ext) ? sum - mod_ext : sum;
    assign last_probe = (r_idx + 1'b1 == i_hashes);

    assign ram_we    = (r_state == S_CLEAR) ||
                       (r_state == S_READ && r_job.op == OpInsert);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_pos[AddrW-1:0];
    assign ram_wdata = (r_state != S_CLEAR);

    bfe_ram #(.Width(1), .Depth(MaxBits)) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos[AddrW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_job_take    = (r_state == S_IDLE) && !r_valid;
    assign o_busy_clear  = (r_state == S_CLEAR);
    assign o_valid       = r_valid;
    assign o_may_contain = r_may_o;
    assign o_in_range    = r_rng_o;

    // sequencer: clear sweep, restoring reduction of key and h2, probe walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AddrW'(MaxBits - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_job_valid && !r_valid) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_may <= i_job.in_range;
                        r_pos <= SumW'(i_job.key);
                        r_red <= SumW'(i_job.key ^ GoldenMix);
                        r_cnt <= 6'd31;
                        if (i_job.probe && (i_job.op == OpInsert || i_job.in_range))
                            r_state <= S_REDUCE;
                        else
                            r_state <= S_OUT;
                    end
                end
                S_REDUCE: begin
                    // both operands reduced by M shifted, one shift a cycle
                    if (ShW'(r_pos) >= mod_sh) r_pos <= r_pos - mod_sh[SumW-1:0];
                    if (ShW'(r_red) >= mod_sh) r_red <= r_red - mod_sh[SumW-1:0];
                    if (r_cnt == '0) begin
                        r_state <= S_READ;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_READ: begin
                    if (r_cnt == '0) r_step <= r_red;
                    r_cnt <= 6'd1;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_job.op == OpQuery && !ram_rdata) r_may <= 1'b0;
                    r_idx <= r_idx + 1'b1;
                    r_pos <= sum_red;
                    if (last_probe || (r_job.op == OpQuery && !ram_rdata))
                        r_state <= S_OUT;
                    else
                        r_state <= S_READ;
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                        r_may_o <= (r_job.op == OpQuery) && r_may;
                        r_rng_o <= r_job.in_range;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/bloom_filter_engine_core.sv
// Bloom filter engine with double hashing over 32-bit signed keys.
// Input channel: i_valid/o_stall with i_op (0 insert, 1 query) and i_key.
// Output channel: o_valid/i_stall with o_may_contain and o_in_range, one
// beat per input beat, in order.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data write num_bits,
// hash_count, min_key and max_key; write only while the engine is idle.
// After reset the bit store is cleared by a sweep over all 65536 bits,
// one bit per cycle; items wait at the input until it ends.
// Each probed key first reduces key and key^0x9e3779b9 modulo num_bits
// in a restoring shift-subtract unit, with num_bits shifted left by 31
// down to 0, then walks the probes, each a memory read followed by a
// check and modular step; a query stops at its first clear bit, and
// items with no probe and out-of-range queries go straight to output.
// A two-entry queue lets the front accept while the back is busy; the
// output register holds a beat while i_stall is high.
module bloom_filter_engine_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  logic signed [31:0]   i_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_may_contain,
    output logic                 o_in_range,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import bfe_pkg::*;

    logic [NumW-1:0]     r_num_bits;
    logic [4:0]          r_hash_count;
    logic signed [31:0]  r_min_key;
    logic signed [31:0]  r_max_key;
    logic [NumW-1:0]     eff_mod;
    logic [HashW-1:0]    eff_hashes;
    logic                probe_en;
    logic                job_valid;
    logic                job_take;
    t_job                job;
    logic                busy_clear;
    logic                front_stall;
    logic                front_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= '0;
            r_hash_count <= '0;
            r_min_key    <= 32'sh80000000;
            r_max_key    <= 32'sh7fffffff;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegNumBits:   r_num_bits   <= i_cfg_data[NumW-1:0];
                RegHashCount: r_hash_count <= i_cfg_data[4:0];
                RegMinKey:    r_min_key    <= i_cfg_data;
                RegMaxKey:    r_max_key    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate size and hash count
    assign eff_mod    = (r_num_bits > NumW'(MaxBits)) ? NumW'(MaxBits) : r_num_bits;
    assign eff_hashes = (r_hash_count > 5'(MaxHashes)) ? HashW'(MaxHashes)
                                                       : HashW'(r_hash_count);
    assign probe_en   = (eff_mod != '0) && (eff_hashes != '0);

    assign front_valid = i_valid && !busy_clear;
    assign o_stall     = front_stall || busy_clear;

    bfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (front_valid),
        .o_stall     (front_stall),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_min_key   (r_min_key),
        .i_max_key   (r_max_key),
        .i_probe_en  (probe_en),
        .o_job_valid (job_valid),
        .i_job_take  (job_take),
        .o_job       (job)
    );

    bfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .o_job_take    (job_take),
        .i_job         (job),
        .i_mod         (eff_mod),
        .i_hashes      (eff_hashes),
        .o_busy_clear  (busy_clear),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_may_contain (o_may_contain),
        .o_in_range    (o_in_range)
    );
endmodule
